### hw/rtl/utf8seg_pkg.sv
// Shared types, constants and checking functions of the UTF-8 stream segmenter.
`default_nettype none

package utf8seg_pkg;

    // Kind tag of an emitted word.
    typedef enum logic [1:0] {
        KIND_VALID  = 2'd0,
        KIND_RAW    = 2'd1,
        KIND_TAIL   = 2'd2,
        KIND_MAPPED = 2'd3
    } kind_t;

    // Input word: a command bit and a data byte.
    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } in_item_t;

    // Output word.
    typedef struct packed {
        logic [7:0] out_byte;
        kind_t      kind;
        logic       last;
    } out_item_t;

    // Input commands.
    localparam logic CMD_DATA  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // Verdict on the bytes at the head of the buffer.
    typedef enum logic [1:0] {
        CLS_NEED  = 2'd0,
        CLS_VALID = 2'd1,
        CLS_BAD   = 2'd2
    } cls_code_t;

    typedef struct packed {
        cls_code_t  code;
        logic [2:0] size;
    } cls_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] ascii;
    } map_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RUN,
        ST_TAIL
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  load;
        logic  emit;
        kind_t kind;
        logic  shift_n;
        logic  load_run;
        logic  dec_run;
        logic  cont;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        cls_code_t  cls;
        logic [2:0] size;
        logic       mapped;
        logic [2:0] len;
        logic       flush;
        logic       run_last;
        logic       out_ready;
    } dp_status_t;

    // Code point limits.
    localparam logic [10:0] CP_MIN2 = 11'h080;
    localparam logic [15:0] CP_MIN3 = 16'h0800;
    localparam logic [15:0] SURR_LO = 16'hD800;
    localparam logic [15:0] SURR_HI = 16'hDFFF;
    localparam logic [20:0] CP_MIN4 = 21'h10000;
    localparam logic [20:0] CP_MAX  = 21'h10FFFF;

    // Byte patterns of the whitespace characters mapped in pretty mode.
    localparam logic [7:0] LEAD_C4  = 8'hC4;
    localparam logic [7:0] LEAD_C2  = 8'hC2;
    localparam logic [7:0] LEAD_E2  = 8'hE2;
    localparam logic [7:0] TRAIL_A0 = 8'hA0;
    localparam logic [7:0] TRAIL_8A = 8'h8A;
    localparam logic [7:0] MID_96   = 8'h96;
    localparam logic [7:0] TRAIL_81 = 8'h81;
    localparam logic [7:0] ASCII_SP = 8'h20;
    localparam logic [7:0] ASCII_NL = 8'h0A;

    // Judge the first character held in bytes (byte 0 in the low bits).
    function automatic cls_t classify(input logic [31:0] bytes, input logic [2:0] len);
        logic [7:0]  c;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [7:0]  b3;
        logic [10:0] cp2;
        logic [15:0] cp3;
        logic [20:0] cp4;
        cls_t        r;
        c   = bytes[7:0];
        b1  = bytes[15:8];
        b2  = bytes[23:16];
        b3  = bytes[31:24];
        cp2 = {c[4:0], b1[5:0]};
        cp3 = {c[3:0], b1[5:0], b2[5:0]};
        cp4 = {c[2:0], b1[5:0], b2[5:0], b3[5:0]};
        r.code = CLS_NEED;
        r.size = 3'd1;
        if (len == 3'd0) begin
            r.code = CLS_NEED;
        end else if (c[7] == 1'b0) begin
            r.code = CLS_VALID;
            r.size = 3'd1;
        end else if (c[7:5] == 3'b110) begin
            if (len < 3'd2) begin
                r.code = CLS_NEED;
            end else if (b1[7:6] != 2'b10 || cp2 < CP_MIN2) begin
                r.code = CLS_BAD;
            end else begin
                r.code = CLS_VALID;
                r.size = 3'd2;
            end
        end else if (c[7:4] == 4'b1110) begin
            if (len < 3'd3) begin
                r.code = CLS_NEED;
            end else if (b1[7:6] != 2'b10 || b2[7:6] != 2'b10 || cp3 < CP_MIN3
                         || (cp3 >= SURR_LO && cp3 <= SURR_HI)) begin
                r.code = CLS_BAD;
            end else begin
                r.code = CLS_VALID;
                r.size = 3'd3;
            end
        end else if (c[7:3] == 5'b11110) begin
            if (len < 3'd4) begin
                r.code = CLS_NEED;
            end else if (b1[7:6] != 2'b10 || b2[7:6] != 2'b10 || b3[7:6] != 2'b10
                         || cp4 < CP_MIN4 || cp4 > CP_MAX) begin
                r.code = CLS_BAD;
            end else begin
                r.code = CLS_VALID;
                r.size = 3'd4;
            end
        end else begin
            r.code = CLS_BAD;
        end
        return r;
    endfunction

    // Whitespace mapping for a valid character of the given size.
    function automatic map_t map_pretty(input logic [31:0] bytes, input logic [2:0] size);
        map_t r;
        r.hit   = 1'b0;
        r.ascii = ASCII_SP;
        if (size == 3'd2 && bytes[7:0] == LEAD_C4 && bytes[15:8] == TRAIL_A0) begin
            r.hit = 1'b1;
        end else if (size == 3'd2 && bytes[7:0] == LEAD_C4 && bytes[15:8] == TRAIL_8A) begin
            r.hit   = 1'b1;
            r.ascii = ASCII_NL;
        end else if (size == 3'd3 && bytes[7:0] == LEAD_E2 && bytes[15:8] == MID_96
                     && bytes[23:16] == TRAIL_81) begin
            r.hit = 1'b1;
        end else if (size == 3'd2 && bytes[7:0] == LEAD_C2 && bytes[15:8] == TRAIL_A0) begin
            r.hit = 1'b1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/utf8_stream_segmenter_top.sv
// Top level of the UTF-8 stream segmenter: controller, datapath and checks.
//
//   channel   signals                        direction
//   input     in_valid, in_stall, in_data    in: one byte or a flush command per word
//   output    out_valid, out_stall, out_data out: one emitted byte per word
//   config    cfg_wr_en, cfg_wr_data         in: pretty mode bit
//
// An input word is accepted, then its output words (up to four) are written one at a time,
// and a final check in the scan state follows unless the word ends by flushing a tail.
// The single output register, filled one byte per cycle unless stalled, sets the pace.
// Reset clears the pending count, pretty mode, the controller and the output valid.
// A stalled output holds the datapath in place; no new word is taken until the last
// result of the current one is in the output register.
`default_nettype none

module utf8_stream_segmenter_top
    import utf8seg_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     cfg_wr_en,
    input  wire logic     cfg_wr_data,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire in_item_t in_data,
    output logic          out_valid,
    input  wire logic     out_stall,
    output out_item_t     out_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencer.
    utf8seg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Buffer, checks and output register.
    utf8seg_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_data     (in_data),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .out_data    (out_data),
        .cmd         (cmd),
        .status      (status)
    );

    // Never more than three bytes pending while a new word may come in.
    assert property (@(posedge clk) disable iff (!rst_n) !in_stall |-> status.len <= 3'd3)
        else $error("pending count above three while idle");

    // The buffer never holds more than four bytes.
    assert property (@(posedge clk) disable iff (!rst_n) status.len <= 3'd4)
        else $error("buffer length out of range");

    // A word is never written over one still waiting on the output.
    assert property (@(posedge clk) disable iff (!rst_n) cmd.emit |-> status.out_ready)
        else $error("output word overwritten");

    // Tail bytes come out only for a flush command.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.kind == KIND_TAIL) |-> status.flush)
        else $error("tail byte emitted without flush");

endmodule

`default_nettype wire

### hw/rtl/utf8seg_dp.sv
// Datapath of the UTF-8 stream segmenter: byte buffer, checks, run counter, output register.
`default_nettype none

module utf8seg_dp
    import utf8seg_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic       cfg_wr_data,
    input  wire in_item_t   in_data,
    input  wire logic       out_stall,
    output logic            out_valid,
    output out_item_t       out_data,
    input  wire dp_cmd_t    cmd,
    output dp_status_t      status
);

    logic [31:0] buf_reg;
    logic [31:0] buf_next;
    logic [2:0]  len_reg;
    logic [2:0]  len_next;
    logic        flush_reg;
    logic        pretty_reg;
    logic [1:0]  run_reg;
    logic        out_valid_reg;
    out_item_t   out_data_reg;

    cls_t        head;
    map_t        map_hit;
    logic [2:0]  shift_amt;
    logic [31:0] rest_buf;
    logic [2:0]  rest_len;
    cls_t        rest_cls;
    logic        rest_more;
    logic        out_ready;
    out_item_t   word_next;

    // Head-of-buffer check and whitespace mapping.
    assign head      = classify(buf_reg, len_reg);
    assign map_hit   = map_pretty(buf_reg, head.size);
    assign out_ready = !out_valid_reg || !out_stall;

    // Buffer after the commanded shift, and whether it still yields a word.
    assign shift_amt = cmd.shift_n ? head.size : 3'd1;
    assign rest_buf  = buf_reg >> {shift_amt, 3'b000};
    assign rest_len  = len_reg - shift_amt;
    assign rest_cls  = classify(rest_buf, rest_len);
    assign rest_more = (rest_len != 3'd0) && (flush_reg || rest_cls.code != CLS_NEED);

    // Status to the controller.
    always_comb
    begin
        status.cls       = head.code;
        status.size      = head.size;
        status.mapped    = pretty_reg && map_hit.hit;
        status.len       = len_reg;
        status.flush     = flush_reg;
        status.run_last  = (run_reg == 2'd1);
        status.out_ready = out_ready;
    end

    // Buffer update: append a data byte on load, shift on emit.
    always_comb
    begin
        buf_next = buf_reg;
        len_next = len_reg;
        if (cmd.load) begin
            if (in_data.command == CMD_DATA) begin
                for (int i = 0; i < 4; i++) begin
                    if (len_reg == 3'(i)) begin
                        buf_next[8*i +: 8] = in_data.data_byte;
                    end
                end
                len_next = len_reg + 3'd1;
            end
        end else if (cmd.emit) begin
            buf_next = rest_buf;
            len_next = rest_len;
        end
    end

    // Word to present next.
    always_comb
    begin
        word_next.out_byte = (cmd.kind == KIND_MAPPED) ? map_hit.ascii : buf_reg[7:0];
        word_next.kind     = cmd.kind;
        word_next.last     = !(cmd.cont || rest_more);
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            len_reg       <= 3'd0;
            pretty_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            len_reg <= len_next;
            if (cfg_wr_en) begin
                pretty_reg <= cfg_wr_data;
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (!out_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
        if (cmd.load) begin
            flush_reg <= in_data.command;
        end
        if (cmd.load_run) begin
            run_reg <= 2'(head.size - 3'd1);
        end else if (cmd.dec_run) begin
            run_reg <= run_reg - 2'd1;
        end
        if (cmd.emit) begin
            out_data_reg <= word_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

### hw/rtl/utf8seg_ctrl.sv
// Controller state machine of the UTF-8 stream segmenter.
`default_nettype none

module utf8seg_ctrl
    import utf8seg_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    // Next state and datapath commands.
    always_comb
    begin
        state_next   = state_reg;
        cmd.load     = 1'b0;
        cmd.emit     = 1'b0;
        cmd.kind     = KIND_VALID;
        cmd.shift_n  = 1'b0;
        cmd.load_run = 1'b0;
        cmd.dec_run  = 1'b0;
        cmd.cont     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.len == 3'd0 || status.cls == CLS_NEED) begin
                    // Incomplete or empty: done, unless a flush sends the tail out raw.
                    if (status.flush && status.len != 3'd0) begin
                        if (status.out_ready) begin
                            cmd.emit   = 1'b1;
                            cmd.kind   = KIND_TAIL;
                            cmd.cont   = (status.len > 3'd1);
                            state_next = (status.len > 3'd1) ? ST_TAIL : ST_IDLE;
                        end
                    end else begin
                        state_next = ST_IDLE;
                    end
                end else if (status.out_ready) begin
                    cmd.emit = 1'b1;
                    if (status.cls == CLS_BAD) begin
                        cmd.kind = KIND_RAW;
                    end else if (status.mapped) begin
                        cmd.kind    = KIND_MAPPED;
                        cmd.shift_n = 1'b1;
                    end else if (status.size != 3'd1) begin
                        cmd.load_run = 1'b1;
                        cmd.cont     = 1'b1;
                        state_next   = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                // Remaining bytes of a valid character, one per cycle while the output is ready.
                if (status.out_ready) begin
                    cmd.emit    = 1'b1;
                    cmd.dec_run = 1'b1;
                    cmd.cont    = !status.run_last;
                    if (status.run_last) begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_TAIL:
            begin
                if (status.out_ready) begin
                    cmd.emit = 1'b1;
                    cmd.kind = KIND_TAIL;
                    cmd.cont = (status.len > 3'd1);
                    if (status.len <= 3'd1) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### tb/sv/utf8_stream_segmenter_top_tb.sv
// Testbench of the UTF-8 stream segmenter: directed and random byte streams checked by a predictor.
`timescale 1ns / 100ps

module utf8_stream_segmenter_top_tb
    import utf8seg_pkg::*;
;

    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT   = 400000;

    // Predicts the emitted words from the accepted input words and checks them in order.
    class segment_tracker;
        logic [7:0]  held [3];
        int unsigned held_count;
        bit          pretty;
        logic [7:0]  work_buf [4];
        int unsigned work_len;
        out_item_t   expected_words [$];
        int unsigned mismatches;

        function new();
            held_count = 0;
            pretty     = 1'b0;
            mismatches = 0;
            work_len   = 0;
            foreach (held[i])
            begin
                held[i] = 8'h00;
            end
        endfunction

        function void set_pretty(input bit mode);
            pretty = mode;
        endfunction

        function void emit(input logic [7:0] value, input kind_t tag);
            out_item_t w;
            w.out_byte = value;
            w.kind     = tag;
            w.last     = 1'b0;
            expected_words.push_back(w);
        endfunction

        // Verdict on the character at the head of the work buffer.
        function cls_code_t judge_head(output int unsigned size);
            logic [7:0]  c;
            logic [20:0] cp;
            int unsigned need;
            int unsigned i;
            c    = work_buf[0];
            size = 1;
            if (work_len == 0)
                return CLS_NEED;
            if (c[7] == 1'b0)
                return CLS_VALID;
            if (c[7:5] == 3'b110)
                need = 2;
            else if (c[7:4] == 4'b1110)
                need = 3;
            else if (c[7:3] == 5'b11110)
                need = 4;
            else
                return CLS_BAD;
            // Nothing is judged until the whole character is present.
            if (work_len < need)
                return CLS_NEED;
            for (i = 1; i < need; i++)
            begin
                if (work_buf[i][7:6] != 2'b10)
                    return CLS_BAD;
            end
            case (need)
                2: cp = {10'd0, c[4:0], work_buf[1][5:0]};
                3: cp = {5'd0, c[3:0], work_buf[1][5:0], work_buf[2][5:0]};
                default: cp = {c[2:0], work_buf[1][5:0], work_buf[2][5:0], work_buf[3][5:0]};
            endcase
            if (need == 2 && cp < 21'h80)
                return CLS_BAD;
            if (need == 3 && (cp < 21'h800 || (cp >= 21'hD800 && cp <= 21'hDFFF)))
                return CLS_BAD;
            if (need == 4 && (cp < 21'h10000 || cp > 21'h10FFFF))
                return CLS_BAD;
            size = need;
            return CLS_VALID;
        endfunction

        // ASCII byte for a whitespace character in pretty mode, or -1.
        function int ascii_for(input int unsigned size);
            if (size == 2 && work_buf[0] == LEAD_C4 && work_buf[1] == TRAIL_A0)
                return ASCII_SP;
            if (size == 2 && work_buf[0] == LEAD_C4 && work_buf[1] == TRAIL_8A)
                return ASCII_NL;
            if (size == 3 && work_buf[0] == LEAD_E2 && work_buf[1] == MID_96
                && work_buf[2] == TRAIL_81)
                return ASCII_SP;
            if (size == 2 && work_buf[0] == LEAD_C2 && work_buf[1] == TRAIL_A0)
                return ASCII_SP;
            return -1;
        endfunction

        // Emit every complete or invalid character at the head of the buffer.
        function void release_chars();
            int unsigned size;
            cls_code_t   verdict;
            int          mapped;
            int unsigned i;
            while (work_len > 0)
            begin
                verdict = judge_head(size);
                if (verdict == CLS_NEED)
                    return;
                if (verdict == CLS_BAD)
                begin
                    // Only the first byte goes out raw; the rest is scanned again.
                    emit(work_buf[0], KIND_RAW);
                    size = 1;
                end
                else
                begin
                    mapped = pretty ? ascii_for(size) : -1;
                    if (mapped >= 0)
                        emit(mapped[7:0], KIND_MAPPED);
                    else
                        for (i = 0; i < size; i++)
                            emit(work_buf[i], KIND_VALID);
                end
                for (i = 0; i + size < work_len; i++)
                    work_buf[i] = work_buf[i + size];
                work_len -= size;
            end
        endfunction

        // Note one accepted input word and queue the words it releases.
        function void take_input(input in_item_t w);
            int unsigned before_n;
            int unsigned i;
            before_n = expected_words.size();
            for (i = 0; i < held_count; i++)
                work_buf[i] = held[i];
            work_len = held_count;
            if (w.command == CMD_FLUSH)
            begin
                release_chars();
                for (i = 0; i < work_len; i++)
                    emit(work_buf[i], KIND_TAIL);
                work_len = 0;
            end
            else
            begin
                work_buf[work_len] = w.data_byte;
                work_len++;
                release_chars();
            end
            held_count = work_len;
            for (i = 0; i < held_count; i++)
                held[i] = work_buf[i];
            if (expected_words.size() > before_n)
                expected_words[expected_words.size() - 1].last = 1'b1;
        endfunction

        // Compare one accepted output word with the oldest expectation.
        function void match_word(input out_item_t got);
            out_item_t want;
            if (expected_words.size() == 0)
            begin
                $error("out word %02h kind %0d arrived with nothing expected",
                       got.out_byte, got.kind);
                mismatches++;
                return;
            end
            want = expected_words.pop_front();
            if (got.out_byte !== want.out_byte)
            begin
                $error("out_byte: expected %02h, actual %02h", want.out_byte, got.out_byte);
                mismatches++;
            end
            if (got.kind !== want.kind)
            begin
                $error("kind: expected %0d, actual %0d", want.kind, got.kind);
                mismatches++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0b, actual %0b", want.last, got.last);
                mismatches++;
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      cfg_wr_en;
    logic      cfg_wr_data;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_data;

    segment_tracker tracker = new();
    in_item_t       stim_words [$];
    logic [7:0]     seq_bytes [4];
    bit             sender_calm;

    utf8_stream_segmenter_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit.
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("** utf8_stream_segmenter_top: FAILED **");
        $finish;
    end

    // Result side: check each accepted word, then stall for a random number of cycles.
    // Now and then it holds off for a long stretch so that the input backs up.
    initial
    begin : result_side
        int stall_left;
        int hold_left;
        int words_taken;
        bit calm;
        out_stall <= 1'b0;
        stall_left  = 0;
        hold_left   = 0;
        words_taken = 0;
        calm        = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
            begin
                tracker.match_word(out_data);
                words_taken++;
                if (words_taken % 150 == 60)
                    hold_left = 300;
                if ($urandom_range(0, 24) == 0)
                    calm = !calm;
                stall_left = calm ? 0 : $urandom_range(0, 14);
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    function automatic void push_byte(input logic [7:0] value);
        in_item_t w;
        w.command   = CMD_DATA;
        w.data_byte = value;
        stim_words.push_back(w);
    endfunction

    // A flush carries a random byte that the block must ignore.
    function automatic void push_flush();
        in_item_t w;
        w.command   = CMD_FLUSH;
        w.data_byte = 8'($urandom_range(0, 255));
        stim_words.push_back(w);
    endfunction

    // Encode a code point in n bytes; short code points give overlong forms.
    function automatic void encode_char(input logic [20:0] cp, input int unsigned n);
        case (n)
            1: seq_bytes[0] = {1'b0, cp[6:0]};
            2:
            begin
                seq_bytes[0] = {3'b110, cp[10:6]};
                seq_bytes[1] = {2'b10, cp[5:0]};
            end
            3:
            begin
                seq_bytes[0] = {4'b1110, cp[15:12]};
                seq_bytes[1] = {2'b10, cp[11:6]};
                seq_bytes[2] = {2'b10, cp[5:0]};
            end
            default:
            begin
                seq_bytes[0] = {5'b11110, cp[20:18]};
                seq_bytes[1] = {2'b10, cp[17:12]};
                seq_bytes[2] = {2'b10, cp[11:6]};
                seq_bytes[3] = {2'b10, cp[5:0]};
            end
        endcase
    endfunction

    // A random legal code point of the given encoded length.
    function automatic logic [20:0] pick_cp(input int unsigned n);
        logic [20:0] cp;
        case (n)
            1: cp = 21'($urandom_range(0, 'h7F));
            2: cp = 21'($urandom_range('h80, 'h7FF));
            3:
            begin
                cp = 21'($urandom_range('h800, 'hF7FF));
                if (cp >= 21'hD800)
                    cp += 21'h800;
            end
            default: cp = 21'($urandom_range('h10000, 'h10FFFF));
        endcase
        return cp;
    endfunction

    // Queue one random sequence: mostly well-formed characters, the rest broken or noise.
    function automatic void build_sequence();
        int unsigned pick;
        int unsigned n;
        int unsigned count;
        int unsigned i;
        logic [20:0] cp;
        logic [7:0]  b;
        pick  = $urandom_range(0, 99);
        n     = 0;
        count = 0;
        if (pick < 40)
        begin
            n = $urandom_range(1, 4);
            encode_char(pick_cp(n), n);
            count = n;
        end
        else if (pick < 50)
        begin
            // Whitespace characters, mapped only in pretty mode.
            case ($urandom_range(0, 3))
                0:
                begin
                    cp = 21'h120;
                    n  = 2;
                end
                1:
                begin
                    cp = 21'h10A;
                    n  = 2;
                end
                2:
                begin
                    cp = 21'h2581;
                    n  = 3;
                end
                default:
                begin
                    cp = 21'hA0;
                    n  = 2;
                end
            endcase
            encode_char(cp, n);
            count = n;
        end
        else if (pick < 56)
        begin
            // Code points at the edges of each length and of the surrogate gap.
            case ($urandom_range(0, 9))
                0: cp = 21'h0;
                1: cp = 21'h7F;
                2: cp = 21'h80;
                3: cp = 21'h7FF;
                4: cp = 21'h800;
                5: cp = 21'hD7FF;
                6: cp = 21'hE000;
                7: cp = 21'hFFFF;
                8: cp = 21'h10000;
                default: cp = 21'h10FFFF;
            endcase
            n = (cp < 'h80) ? 1 : (cp < 'h800) ? 2 : (cp < 'h10000) ? 3 : 4;
            encode_char(cp, n);
            count = n;
        end
        else if (pick < 62)
        begin
            n = $urandom_range(2, 4);
            cp = 21'($urandom_range(0, (n == 2) ? 'h7F : (n == 3) ? 'h7FF : 'hFFFF));
            encode_char(cp, n);
            count = n;
        end
        else if (pick < 66)
        begin
            encode_char(21'($urandom_range('hD800, 'hDFFF)), 3);
            count = 3;
        end
        else if (pick < 70)
        begin
            encode_char(21'($urandom_range('h110000, 'h1FFFFF)), 4);
            count = 4;
        end
        else if (pick < 76)
        begin
            // One continuation byte replaced by something else.
            n = $urandom_range(2, 4);
            encode_char(pick_cp(n), n);
            b = 8'($urandom_range(0, 255));
            if (b[7:6] == 2'b10)
                b[6] = 1'b1;
            seq_bytes[$urandom_range(1, n - 1)] = b;
            count = n;
        end
        else if (pick < 82)
        begin
            // Character cut short, then either flushed or followed by a new one.
            n = $urandom_range(2, 4);
            encode_char(pick_cp(n), n);
            count = $urandom_range(1, n - 1);
        end
        else if (pick < 86)
        begin
            if ($urandom_range(0, 1) == 0)
                seq_bytes[0] = 8'($urandom_range('h80, 'hBF));
            else
                seq_bytes[0] = 8'($urandom_range('hF8, 'hFF));
            count = 1;
        end
        else if (pick < 92)
        begin
            count = $urandom_range(1, 3);
            for (i = 0; i < count; i++)
                seq_bytes[i] = 8'($urandom_range(0, 255));
        end
        for (i = 0; i < count; i++)
            push_byte(seq_bytes[i]);
        if (pick >= 92 || (pick >= 76 && pick < 82 && $urandom_range(0, 1) == 1))
            push_flush();
    endfunction

    // Offer one word after a random gap and wait until it is accepted.
    task automatic send_word(input in_item_t w);
        int gap;
        if ($urandom_range(0, 24) == 0)
            sender_calm = !sender_calm;
        gap = sender_calm ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_data  <= w;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        tracker.take_input(w);
    endtask

    // Stop offering, wait for every expected word, then let the block finish its work.
    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_pretty(input bit mode);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        tracker.set_pretty(mode);
    endtask

    task automatic send_queued();
        while (stim_words.size() != 0)
            send_word(stim_words.pop_front());
    endtask

    // Random words until the target count; optionally drain once half way.
    task automatic run_random(input int target, input bit pause_midway);
        int sent;
        sent = 0;
        while (sent < target)
        begin
            build_sequence();
            while (stim_words.size() != 0)
            begin
                send_word(stim_words.pop_front());
                sent++;
                if (pause_midway && sent == target / 2)
                    settle();
            end
        end
    endtask

    // Main sequence: reset, directed words, then random phases in both modes.
    initial
    begin : stimulus
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 1'b0;
        in_valid    <= 1'b0;
        in_data     <= '0;
        sender_calm = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part in pretty mode: ASCII extremes, the four whitespace
        // characters, the highest code point, a surrogate, an overlong pair,
        // a bad lead byte, a cut sequence with a wrong early byte, and flushes.
        write_pretty(1'b1);
        push_byte(8'h00);
        push_byte(8'h7F);
        push_byte(8'hC4); push_byte(8'hA0);
        push_byte(8'hC4); push_byte(8'h8A);
        push_byte(8'hE2); push_byte(8'h96); push_byte(8'h81);
        push_byte(8'hC2); push_byte(8'hA0);
        push_byte(8'hF4); push_byte(8'h8F); push_byte(8'hBF); push_byte(8'hBF);
        push_byte(8'hED); push_byte(8'hA0); push_byte(8'h80);
        push_byte(8'hC0); push_byte(8'h80);
        push_byte(8'hFF);
        push_byte(8'hE2); push_byte(8'h41);
        push_flush();
        push_flush();
        send_queued();
        settle();

        write_pretty(1'b0);
        run_random(80, 1'b1);
        settle();
        write_pretty(1'b1);
        run_random(80, 1'b0);
        settle();
        write_pretty(1'b0);
        run_random(80, 1'b0);
        settle();
        write_pretty(1'b1);
        run_random(80, 1'b0);
        settle();

        if (tracker.expected_words.size() != 0)
        begin
            $error("%0d expected words never arrived", tracker.expected_words.size());
            tracker.mismatches++;
        end
        if (tracker.mismatches == 0)
            $display("** utf8_stream_segmenter_top: PASSED **");
        else
            $display("** utf8_stream_segmenter_top: FAILED **");
        $finish;
    end

endmodule
